>>> rtl/traffic_gen_fifo_node_defines.svh
// Assertion macros shared by the node RTL.
// No dependencies.
`ifndef TRAFFIC_GEN_FIFO_NODE_DEFINES_SVH
`define TRAFFIC_GEN_FIFO_NODE_DEFINES_SVH
`define TGN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TGN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> rtl/tgn_pkg.sv
// Types and constants for the traffic generator node.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tgn_pkg;
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] SYNC_BARRIER = 2'd0;
    localparam logic [1:0] SYNC_NEVER   = 2'd1;
    localparam logic [1:0] SYNC_WINDOW  = 2'd2;
    localparam logic [1:0] SYNC_RSVD    = 2'd3;

    localparam logic [2:0] REG_CHIP_ID   = 3'd0;
    localparam logic [2:0] REG_IN_EN     = 3'd1;
    localparam logic [2:0] REG_OUT_EN    = 3'd2;
    localparam logic [2:0] REG_RATE      = 3'd3;
    localparam logic [2:0] REG_SEED      = 3'd4;
    localparam logic [2:0] REG_WINDOW    = 3'd5;
    localparam logic [2:0] REG_SYNC      = 3'd6;

    localparam logic [31:0] PPM_SCALE = 32'd1000000;
    localparam logic [31:0] SEED_MIX  = 32'd2654435761;
    // ceil(2^50 / 1000000): exact quotient for any 32-bit word after a shift by 50
    localparam logic [31:0] PPM_RECIP = 32'h431BDE83;

    localparam int QUEUE_SLOTS = 32;
    localparam int QUEUE_AW    = $clog2(QUEUE_SLOTS);
    localparam int QUEUE_CW    = $clog2(QUEUE_SLOTS + 1);

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] tick_seq;
        logic        nb_valid;
        logic [31:0] nb_source;
        logic [63:0] nb_time;
        logic [23:0] nb_payload;
        logic [63:0] nb_local_seq;
    } t_in;

    typedef struct packed {
        logic        tx_valid;
        logic [31:0] tx_source;
        logic [63:0] tx_time;
        logic [23:0] tx_payload;
        logic [63:0] tx_local_seq;
        logic        done_flag;
        logic [5:0]  occupancy;
        logic [63:0] sent_total;
        logic [63:0] received_total;
        logic [63:0] generated_total;
        logic [63:0] dropped_total;
        logic [5:0]  peak_occupancy;
    } t_out;

    typedef struct packed {
        logic [31:0] source;
        logic [63:0] time_v;
        logic [23:0] payload;
        logic [63:0] local_seq;
    } t_pkt;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RNG1, ST_QUO, ST_MOD, ST_RNG2, ST_POP, ST_POPW,
        ST_PUSH_L, ST_PUSH_N, ST_WAITDIV, ST_OUT
    } t_state;

    function automatic logic [31:0] xorshift(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction
endpackage
`default_nettype wire

>>> rtl/tgn_div.sv
// Bit-serial remainder of a 64-bit dividend by a 16- or 32-bit divisor.
// Depends on tgn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tgn_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_busy,
    output logic [31:0]      o_rem
);
    import tgn_pkg::*;
    logic [63:0] r_num;
    logic [32:0] r_rem, n_rem_sh;
    logic [6:0]  r_cnt;
    logic [31:0] r_den;

    assign n_rem_sh = {r_rem[31:0], r_num[63]};
    assign o_busy   = (r_cnt != 7'd0);
    assign o_rem    = r_rem[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 7'd64;
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (o_busy) begin
            r_cnt <= r_cnt - 7'd1;
            r_num <= {r_num[62:0], 1'b0};
            r_rem <= (n_rem_sh >= {1'b0, r_den}) ? n_rem_sh - {1'b0, r_den} : n_rem_sh;
        end
    end
endmodule
`default_nettype wire

>>> rtl/tgn_fifo_mem.sv
// Packet store of the node FIFO: one write port, one registered read port.
// Depends on tgn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tgn_fifo_mem (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [tgn_pkg::QUEUE_AW-1:0] i_waddr,
    input  wire tgn_pkg::t_pkt                i_wdata,
    input  wire logic [tgn_pkg::QUEUE_AW-1:0] i_raddr,
    output tgn_pkg::t_pkt                     o_rdata
);
    import tgn_pkg::*;
    t_pkt r_mem [QUEUE_SLOTS];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/traffic_gen_fifo_node.sv
// Traffic generator node: per-transaction sequencer over a packet FIFO memory.
// Start/stop/unused op result in the cycle after acceptance; a tick steps RNG1 to
// PUSH_N, then waits in WAITDIV for the bit-serial 64-bit remainder for the windowed
// done flag (other steps overlap it); stalls hold the result; new ops only in IDLE.
// Reset (synchronous, active low): registers to defaults, FIFO empty, counters zero,
// generator loaded with seed 1; FIFO contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
`include "traffic_gen_fifo_node_defines.svh"
module traffic_gen_fifo_node (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire tgn_pkg::t_in i_data,
    output logic              o_valid,
    input  wire logic         i_stall,
    output tgn_pkg::t_out     o_data,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import tgn_pkg::*;
    localparam int AW = QUEUE_AW;
    localparam int CW = QUEUE_CW;
    localparam logic [CW-1:0] FULL = CW'(QUEUE_SLOTS);
    localparam logic [AW-1:0] LAST = AW'(QUEUE_SLOTS - 1);

    logic [15:0] r_chip_id;
    logic        r_in_en, r_out_en;
    logic [19:0] r_rate;
    logic [31:0] r_seed;
    logic [15:0] r_window;
    logic [1:0]  r_sync;

    t_state r_state, n_state;
    t_in    r_in;
    logic [31:0] r_rng;
    logic [12:0] r_quo;
    logic [AW-1:0] r_head, r_tail;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_peak;
    logic [63:0] r_sent, r_recv, r_gen, r_drop;
    logic        r_have_local;
    logic [23:0] r_local_pay;
    logic [63:0] r_local_seq;
    logic        r_tx_valid;
    t_pkt        r_tx;
    logic        r_done;
    logic        r_out_valid;

    logic        wr, cfg_we;
    logic [2:0]  widx;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    t_pkt        mem_wdata, mem_rdata;
    logic        div_start, div_busy;
    logic [31:0] div_rem;
    logic        acc_in, have_nb, full_now;
    logic [AW-1:0] tail_inc;
    logic [63:0] quo_prod;
    logic [31:0] rem32;
    logic [31:0] rng_nx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign widx   = paddr[4:2];
    assign cfg_we = wr;

    always_comb begin
        unique case (widx)
            REG_CHIP_ID: prdata = {16'd0, r_chip_id};
            REG_IN_EN:   prdata = {31'd0, r_in_en};
            REG_OUT_EN:  prdata = {31'd0, r_out_en};
            REG_RATE:    prdata = {12'd0, r_rate};
            REG_SEED:    prdata = r_seed;
            REG_WINDOW:  prdata = {16'd0, r_window};
            REG_SYNC:    prdata = {30'd0, r_sync};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chip_id <= '0; r_in_en <= 1'b0; r_out_en <= 1'b0;
            r_rate <= 20'd100000; r_seed <= 32'd1; r_window <= 16'd4; r_sync <= '0;
        end else if (cfg_we) begin
            unique case (widx)
                REG_CHIP_ID: r_chip_id <= pwdata[15:0];
                REG_IN_EN:   r_in_en   <= pwdata[0];
                REG_OUT_EN:  r_out_en  <= pwdata[0];
                REG_RATE:    r_rate    <= pwdata[19:0];
                REG_SEED:    r_seed    <= pwdata;
                REG_WINDOW:  r_window  <= pwdata[15:0];
                REG_SYNC:    r_sync    <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign acc_in  = i_valid && !o_stall;
    assign have_nb = r_in.nb_valid && r_in_en;
    assign full_now = (r_count >= FULL);
    assign tail_inc = (r_tail == LAST) ? '0 : r_tail + AW'(1);
    assign quo_prod = 64'(r_rng) * 64'(PPM_RECIP);
    assign rem32   = r_rng - 32'(r_quo) * PPM_SCALE;
    assign rng_nx  = xorshift(r_rng);

    tgn_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(r_in.tick_seq + 64'd1), .i_den({16'd0, r_window}),
        .o_busy(div_busy), .o_rem(div_rem)
    );

    tgn_fifo_mem u_mem (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_waddr), .i_wdata(mem_wdata),
        .i_raddr(r_head), .o_rdata(mem_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (acc_in) n_state = (i_data.op == OP_TICK) ? ST_RNG1 : ST_OUT;
            ST_RNG1:    n_state = ST_QUO;
            ST_QUO:     n_state = ST_MOD;
            ST_MOD:     n_state = ST_RNG2;
            ST_RNG2:    n_state = ST_POP;
            ST_POP:     n_state = ST_POPW;
            ST_POPW:    n_state = ST_PUSH_L;
            ST_PUSH_L:  n_state = ST_PUSH_N;
            ST_PUSH_N:  n_state = ST_WAITDIV;
            ST_WAITDIV: if (!div_busy) n_state = ST_OUT;
            ST_OUT:     if (!i_stall) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        div_start = (r_state == ST_RNG1);
        mem_we    = 1'b0;
        mem_waddr = r_tail;
        mem_wdata = '0;
        if (r_state == ST_PUSH_L && r_have_local && !full_now) begin
            mem_we    = 1'b1;
            mem_wdata = '{source: {16'd0, r_chip_id}, time_v: r_in.tick_seq,
                          payload: r_local_pay, local_seq: r_local_seq};
        end else if (r_state == ST_PUSH_N && have_nb && !full_now) begin
            mem_we    = 1'b1;
            mem_wdata = '{source: r_in.nb_source, time_v: r_in.nb_time,
                          payload: r_in.nb_payload, local_seq: r_in.nb_local_seq};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rng <= 32'd1;
            r_head <= '0; r_tail <= '0; r_count <= '0; r_peak <= '0;
            r_sent <= '0; r_recv <= '0; r_gen <= '0; r_drop <= '0;
            r_out_valid <= 1'b0;
            r_have_local <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state) inside
                ST_IDLE: if (acc_in) begin
                    r_in <= i_data;
                    r_tx_valid <= 1'b0; r_tx <= '0; r_done <= 1'b0;
                    if (i_data.op == OP_START) begin
                        r_rng <= r_seed ^ (32'(r_chip_id) * SEED_MIX);
                        r_head <= '0; r_tail <= '0; r_count <= '0; r_peak <= '0;
                        r_sent <= '0; r_recv <= '0; r_gen <= '0; r_drop <= '0;
                    end
                end
                ST_RNG1: begin
                    r_rng <= rng_nx;
                    if (have_nb) r_recv <= r_recv + 64'd1;
                end
                ST_QUO: r_quo <= quo_prod[62:50];
                ST_MOD: r_have_local <= ({12'd0, r_rate} > rem32);
                ST_RNG2: if (r_have_local) begin
                    r_rng <= rng_nx;
                    r_local_pay <= rng_nx[23:0];
                    r_local_seq <= r_gen;
                    r_gen <= r_gen + 64'd1;
                end
                ST_POPW: if (r_count != '0) begin
                    if (r_out_en) begin
                        r_tx_valid <= 1'b1;
                        r_tx <= mem_rdata;
                        r_sent <= r_sent + 64'd1;
                    end
                    r_head <= (r_head == LAST) ? '0 : r_head + AW'(1);
                    r_count <= r_count - CW'(1);
                end
                ST_PUSH_L, ST_PUSH_N: begin
                    if ((r_state == ST_PUSH_L) ? r_have_local : have_nb) begin
                        if (full_now) r_drop <= r_drop + 64'd1;
                        else begin
                            r_tail <= tail_inc;
                            r_count <= r_count + CW'(1);
                        end
                    end
                end
                ST_WAITDIV: if (!div_busy) begin
                    if (r_count > r_peak) r_peak <= r_count;
                    r_done <= (r_sync == SYNC_BARRIER) ||
                        (r_sync == SYNC_WINDOW && r_window != '0 && div_rem == '0);
                end
                default: ;
            endcase
            if (n_state == ST_OUT && r_state != ST_OUT) r_out_valid <= 1'b1;
            else if (r_state == ST_OUT && !i_stall) r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    always_comb begin
        o_data = '0;
        o_data.tx_valid        = r_tx_valid;
        o_data.tx_source       = r_tx.source;
        o_data.tx_time         = r_tx.time_v;
        o_data.tx_payload      = r_tx.payload;
        o_data.tx_local_seq    = r_tx.local_seq;
        o_data.done_flag       = r_done;
        o_data.occupancy       = 6'(r_count);
        o_data.sent_total      = r_sent;
        o_data.received_total  = r_recv;
        o_data.generated_total = r_gen;
        o_data.dropped_total   = r_drop;
        o_data.peak_occupancy  = 6'(r_peak);
    end

    `TGN_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL)
    `TGN_ASSERT_IMP(a_valid_out_state, i_clk, i_rst_n, o_valid, r_state == ST_OUT)
    `TGN_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, mem_we, r_count < FULL)
endmodule
`default_nettype wire

>>> tb/tb.sv
// Testbench for traffic_gen_fifo_node: directed table then random, mostly tick, items, checked
// against a behavioural predictor of the node. Depends on tgn_pkg and the node RTL.
`timescale 1ns / 1ps
module tb;
    import tgn_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall_o;
    t_in         in_data = '0;
    logic        out_valid;
    logic        rx_stall = 1'b0;
    t_out        out_data;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    traffic_gen_fifo_node u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall_o),
        .i_data(in_data), .o_valid(out_valid), .i_stall(rx_stall), .o_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor state
    logic [15:0] m_chip;
    logic        m_in_en, m_out_en;
    logic [19:0] m_rate;
    logic [31:0] m_seed;
    logic [15:0] m_window;
    logic [1:0]  m_sync;
    logic [31:0] m_rng;
    t_pkt        m_fifo [QUEUE_SLOTS];
    int          m_head, m_tail, m_count;
    logic [63:0] m_sent, m_recv, m_gen, m_drop;
    logic [5:0]  m_peak;

    t_out  expected_q [$];
    int    errors = 0;
    int    send_idle_pct = 0, stall_pct = 0;
    bit    hold_rx = 1'b0;
    longint cycles = 0;

    function automatic logic [31:0] rng_next();
        logic [31:0] x;
        x = m_rng;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        m_rng = x;
        return x;
    endfunction

    function automatic void node_restart();
        m_rng = m_seed ^ (32'(m_chip) * SEED_MIX);
        m_head = 0; m_tail = 0; m_count = 0;
        m_sent = 0; m_recv = 0; m_gen = 0; m_drop = 0; m_peak = 0;
    endfunction

    function automatic void fifo_push(t_pkt p);
        if (m_count >= QUEUE_SLOTS) begin
            m_drop++;
        end else begin
            m_fifo[m_tail] = p;
            m_tail = (m_tail + 1) % QUEUE_SLOTS;
            m_count++;
        end
    endfunction

    function automatic t_out node_predict(t_in t);
        t_out r;
        t_pkt lp, np;
        bit   have_nb, have_loc;
        r = '0;
        have_loc = 1'b0;
        if (t.op == OP_START) begin
            node_restart();
        end else if (t.op == OP_TICK) begin
            have_nb = t.nb_valid && m_in_en;
            if (have_nb) m_recv++;
            if ((rng_next() % PPM_SCALE) < 32'(m_rate)) begin
                lp.payload = 24'(rng_next());
                lp.source = 32'(m_chip);
                lp.time_v = t.tick_seq;
                lp.local_seq = m_gen;
                have_loc = 1'b1;
                m_gen++;
            end
            if (m_count > 0) begin
                if (m_out_en) begin
                    r.tx_valid = 1'b1;
                    r.tx_source = m_fifo[m_head].source;
                    r.tx_time = m_fifo[m_head].time_v;
                    r.tx_payload = m_fifo[m_head].payload;
                    r.tx_local_seq = m_fifo[m_head].local_seq;
                    m_sent++;
                end
                m_head = (m_head + 1) % QUEUE_SLOTS;
                m_count--;
            end
            if (have_loc) fifo_push(lp);
            if (have_nb) begin
                np.source = t.nb_source; np.time_v = t.nb_time;
                np.payload = t.nb_payload; np.local_seq = t.nb_local_seq;
                fifo_push(np);
            end
            if (m_count > m_peak) m_peak = 6'(m_count);
            if (m_sync == SYNC_BARRIER) r.done_flag = 1'b1;
            else if (m_sync == SYNC_WINDOW && m_window != 0)
                r.done_flag = ((t.tick_seq + 64'd1) % 64'(m_window)) == 0;
        end
        r.occupancy = 6'(m_count);
        r.sent_total = m_sent; r.received_total = m_recv;
        r.generated_total = m_gen; r.dropped_total = m_drop;
        r.peak_occupancy = m_peak;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_CHIP_ID: m_chip = val[15:0];
            REG_IN_EN:   m_in_en = val[0];
            REG_OUT_EN:  m_out_en = val[0];
            REG_RATE:    m_rate = val[19:0];
            REG_SEED:    m_seed = val;
            REG_WINDOW:  m_window = val[15:0];
            REG_SYNC:    m_sync = val[1:0];
            default: ;
        endcase
    endtask

    task automatic send_item(t_in t);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1; in_data <= t;
        expected_q.push_back(node_predict(t));
        do @(posedge clk); while (in_stall_o);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic t_in rand_item(bit tick_only);
        t_in t;
        t.op = tick_only ? OP_TICK : 2'($urandom_range(3));
        if ($urandom_range(9) == 0) t.op = 2'($urandom_range(3));
        t.tick_seq = {$urandom, $urandom};
        if ($urandom_range(15) == 0) t.tick_seq = 64'hFFFF_FFFF_FFFF_FFFF;
        t.nb_valid = 1'($urandom_range(1));
        t.nb_source = $urandom;
        t.nb_time = {$urandom, $urandom};
        t.nb_payload = 24'($urandom);
        t.nb_local_seq = {$urandom, $urandom};
        return t;
    endfunction

    // receive side and checker
    always @(posedge clk) begin
        t_out w;
        cycles <= cycles + 1;
        if (cycles > 64'd3000000) begin
            $display("traffic_gen_fifo_node verification failed");
            $finish;
        end
        rx_stall <= hold_rx || (stall_pct > 0 && $urandom_range(99) < stall_pct);
        if (rst_n && out_valid && !rx_stall) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected transaction", 0, 0);
            end else begin
                w = expected_q.pop_front();
                if (out_data.tx_valid !== w.tx_valid)
                    report_mismatch("tx_valid", out_data.tx_valid, w.tx_valid);
                if (out_data.tx_source !== w.tx_source)
                    report_mismatch("tx_source", out_data.tx_source, w.tx_source);
                if (out_data.tx_time !== w.tx_time)
                    report_mismatch("tx_time", out_data.tx_time, w.tx_time);
                if (out_data.tx_payload !== w.tx_payload)
                    report_mismatch("tx_payload", out_data.tx_payload, w.tx_payload);
                if (out_data.tx_local_seq !== w.tx_local_seq)
                    report_mismatch("tx_local_seq", out_data.tx_local_seq, w.tx_local_seq);
                if (out_data.done_flag !== w.done_flag)
                    report_mismatch("done_flag", out_data.done_flag, w.done_flag);
                if (out_data.occupancy !== w.occupancy)
                    report_mismatch("occupancy", out_data.occupancy, w.occupancy);
                if (out_data.sent_total !== w.sent_total)
                    report_mismatch("sent_total", out_data.sent_total, w.sent_total);
                if (out_data.received_total !== w.received_total)
                    report_mismatch("received_total", out_data.received_total,
                                    w.received_total);
                if (out_data.generated_total !== w.generated_total)
                    report_mismatch("generated_total", out_data.generated_total,
                                    w.generated_total);
                if (out_data.dropped_total !== w.dropped_total)
                    report_mismatch("dropped_total", out_data.dropped_total,
                                    w.dropped_total);
                if (out_data.peak_occupancy !== w.peak_occupancy)
                    report_mismatch("peak_occupancy", out_data.peak_occupancy,
                                    w.peak_occupancy);
            end
        end
    end

    // directed table: op, seq, nb fields; literal marks rows with a literal expectation
    typedef struct {
        t_in  item;
        bit   literal;
        t_out want;
    } t_row;

    initial begin
        t_row rows [$];
        t_row rw;
        int   i, ph;
        m_chip = 0; m_in_en = 0; m_out_en = 0; m_rate = 20'd100000;
        m_seed = 32'd1; m_window = 16'd4; m_sync = SYNC_BARRIER;
        node_restart();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset: stop and unused ops report zeros, ticks run on reset state, start clears to zeros
        rw.item = '0; rw.item.op = OP_STOP; rw.literal = 1; rw.want = '0; rows.push_back(rw);
        rw.item = '0; rw.item.op = OP_NONE; rw.literal = 1; rw.want = '0; rows.push_back(rw);
        rw.literal = 0;
        for (i = 0; i < 3; i++) begin
            rw.item = '0; rw.item.op = OP_TICK; rw.item.nb_valid = 1'b1;
            rw.item.tick_seq = 64'(i); rows.push_back(rw);
        end
        rw.item = '0; rw.item.op = OP_START; rw.literal = 1; rw.want = '0; rows.push_back(rw);
        foreach (rows[k]) begin
            send_item(rows[k].item);
            if (rows[k].literal && expected_q[$] !== rows[k].want)
                report_mismatch("directed row predictor", k, 0);
        end
        drain();

        // extremes: all enabled, rate above a million, windowed with wrap
        reg_write(REG_CHIP_ID, 32'hFFFF);
        reg_write(REG_IN_EN, 32'd1);
        reg_write(REG_OUT_EN, 32'd1);
        reg_write(REG_RATE, 32'hFFFFF);
        reg_write(REG_SEED, 32'hFFFF_FFFF);
        reg_write(REG_WINDOW, 32'd1);
        reg_write(REG_SYNC, 32'(SYNC_WINDOW));
        rows.delete();
        rw.literal = 0;
        rw.item = '0; rw.item.op = OP_START; rows.push_back(rw);
        rw.item = '1; rw.item.op = OP_TICK; rows.push_back(rw);
        rw.item = '0; rw.item.op = OP_TICK; rw.item.nb_valid = 1'b1; rows.push_back(rw);
        rw.item = '1; rw.item.op = OP_TICK; rows.push_back(rw);
        rw.item = '0; rw.item.op = OP_STOP; rows.push_back(rw);
        rw.item = '1; rw.item.op = OP_TICK; rw.item.nb_valid = 1'b0; rows.push_back(rw);
        foreach (rows[k]) send_item(rows[k].item);
        drain();
        reg_write(REG_WINDOW, 32'd0);
        reg_write(REG_SYNC, 32'(SYNC_NEVER));
        rw.item = '1; rw.item.op = OP_TICK; send_item(rw.item);
        drain();
        reg_write(REG_SYNC, 32'(SYNC_RSVD));
        rw.item = '0; rw.item.op = OP_TICK; send_item(rw.item);
        drain();
        reg_write(REG_RATE, 32'd0);
        reg_write(REG_CHIP_ID, 32'd0);
        reg_write(REG_SEED, 32'd0);
        rw.item = '1; rw.item.op = OP_TICK; send_item(rw.item);
        rw.item = '0; rw.item.op = OP_START; send_item(rw.item);
        drain();

        // random phases with differing settings, idling and receive stalls
        for (ph = 0; ph < 8; ph++) begin
            reg_write(REG_CHIP_ID, $urandom_range(65535));
            reg_write(REG_IN_EN, $urandom_range(1));
            reg_write(REG_OUT_EN, (ph == 2) ? 0 : $urandom_range(1));
            reg_write(REG_RATE, (ph % 3 == 0) ? 1000000 : $urandom_range(1048575));
            reg_write(REG_SEED, $urandom);
            reg_write(REG_WINDOW, (ph == 5) ? 65535 : $urandom_range(1, 8));
            reg_write(REG_SYNC, $urandom_range(3));
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 76; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 76; end
                default: begin send_idle_pct = 15; stall_pct = 15; end
            endcase
            rw.item = '0; rw.item.op = OP_START; send_item(rw.item);
            if (ph == 3) fork
                begin
                    int c;
                    hold_rx = 1'b1;
                    for (c = 0; c < 400; c++) @(posedge clk);
                    hold_rx = 1'b0;
                end
            join_none
            for (i = 0; i < 160; i++) send_item(rand_item($urandom_range(9) != 0));
            drain();
        end
        send_idle_pct = 0; stall_pct = 0;
        drain();
        if (errors == 0) begin
            $display("traffic_gen_fifo_node verification clean");
        end else begin
            $display("traffic_gen_fifo_node verification failed");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl
rtl/tgn_pkg.sv
rtl/tgn_div.sv
rtl/tgn_fifo_mem.sv
rtl/traffic_gen_fifo_node.sv
tb/tb.sv
